// ----- hdl/sqsw_pkg.sv -----
package sqsw_pkg;

    localparam int PERIOD_BITS    = 11;
    localparam int PACE_BITS      = 3;
    localparam int SHIFT_BITS     = 3;
    localparam int DUTY_SEL_BITS  = 2;
    localparam int DUTY_STEPS     = 8;
    localparam int VOL_BITS       = 4;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 3;

    localparam int IN_FIELD_BITS   = PERIOD_BITS + VOL_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = PERIOD_BITS + 1 + VOL_BITS + 1;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [DUTY_STEPS-1:0] DUTY_POS_RESET = 8'h80;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LOAD,
        MODE_TRIGGER,
        MODE_TICK,
        MODE_DUTY
    } t_mode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SWEEP_PACE,
        CFG_SWEEP_DOWN,
        CFG_SWEEP_SHIFT,
        CFG_DUTY_SELECT
    } t_cfg_index;

    typedef struct packed {
        logic [PACE_BITS-1:0]     sweep_pace;
        logic                     sweep_down;
        logic [SHIFT_BITS-1:0]    sweep_shift;
        logic [DUTY_SEL_BITS-1:0] duty_select;
    } t_cfg;

    typedef struct packed {
        logic                   duty_high;
        logic [VOL_BITS-1:0]    sample;
        logic                   enabled;
        logic [PERIOD_BITS-1:0] period;
    } t_result;

    typedef struct packed {
        logic                   overflow;
        logic [PERIOD_BITS-1:0] value;
    } t_sweep;

    function automatic t_sweep sweep_calc(
        input logic [PERIOD_BITS-1:0] shadow,
        input logic                   down,
        input logic [SHIFT_BITS-1:0]  shift
    );
        logic [PERIOD_BITS-1:0] delta;
        logic [PERIOD_BITS:0]   wide;
        t_sweep                 res;
        delta = shadow >> shift;
        if (down) begin
            wide = {1'b0, shadow} - {1'b0, delta};
        end else begin
            wide = {1'b0, shadow} + {1'b0, delta};
        end
        res.overflow = wide[PERIOD_BITS];
        res.value    = wide[PERIOD_BITS-1:0];
        return res;
    endfunction

    function automatic logic [DUTY_STEPS-1:0] duty_pattern(
        input logic [DUTY_SEL_BITS-1:0] sel
    );
        logic [DUTY_STEPS-1:0] pat;
        case (sel)
            2'd0:    pat = 8'h01;
            2'd1:    pat = 8'h81;
            2'd2:    pat = 8'h87;
            default: pat = 8'h7E;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/sqsw_cfg.sv -----
module sqsw_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [sqsw_pkg::CFG_INDEX_BITS-1:0] i_index,
    input  logic [sqsw_pkg::CFG_DATA_BITS-1:0]  i_data,
    output sqsw_pkg::t_cfg                      o_cfg
);

    sqsw_pkg::t_cfg r_cfg;
    sqsw_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (sqsw_pkg::t_cfg_index'(i_index))
                sqsw_pkg::CFG_SWEEP_PACE: begin
                    n_cfg.sweep_pace = i_data[sqsw_pkg::PACE_BITS-1:0];
                end
                sqsw_pkg::CFG_SWEEP_DOWN: begin
                    n_cfg.sweep_down = i_data[0];
                end
                sqsw_pkg::CFG_SWEEP_SHIFT: begin
                    n_cfg.sweep_shift = i_data[sqsw_pkg::SHIFT_BITS-1:0];
                end
                sqsw_pkg::CFG_DUTY_SELECT: begin
                    n_cfg.duty_select = i_data[sqsw_pkg::DUTY_SEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/sqsw_core.sv -----
module sqsw_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  sqsw_pkg::t_mode                  i_mode,
    input  logic [sqsw_pkg::PERIOD_BITS-1:0] i_period_in,
    input  logic [sqsw_pkg::VOL_BITS-1:0]    i_volume,
    input  sqsw_pkg::t_cfg                   i_cfg,
    output sqsw_pkg::t_result                o_result
);

    logic [sqsw_pkg::DUTY_STEPS-1:0]  r_duty_pos, n_duty_pos;
    logic                             r_active, n_active;
    logic [sqsw_pkg::PACE_BITS-1:0]   r_count, n_count;
    logic [sqsw_pkg::PERIOD_BITS-1:0] r_shadow, n_shadow;
    logic [sqsw_pkg::PERIOD_BITS-1:0] r_period, n_period;
    logic                             r_on, n_on;

    logic [sqsw_pkg::PERIOD_BITS-1:0] w_sweep_base;
    logic [sqsw_pkg::PACE_BITS-1:0]   w_count_dec;
    sqsw_pkg::t_sweep                 w_sweep_a;
    sqsw_pkg::t_sweep                 w_sweep_b;
    logic                             w_high;

    assign w_sweep_base = (i_mode == sqsw_pkg::MODE_TRIGGER) ? r_period : r_shadow;
    assign w_sweep_a    = sqsw_pkg::sweep_calc(w_sweep_base, i_cfg.sweep_down,
                                               i_cfg.sweep_shift);
    assign w_sweep_b    = sqsw_pkg::sweep_calc(w_sweep_a.value, i_cfg.sweep_down,
                                               i_cfg.sweep_shift);
    assign w_count_dec  = r_count - 1'b1;

    always_comb begin
        n_duty_pos = r_duty_pos;
        n_active   = r_active;
        n_count    = r_count;
        n_shadow   = r_shadow;
        n_period   = r_period;
        n_on       = r_on;
        unique case (i_mode)
            sqsw_pkg::MODE_LOAD: begin
                n_period = i_period_in;
            end
            sqsw_pkg::MODE_TRIGGER: begin
                n_on     = 1'b1;
                n_shadow = r_period;
                n_count  = i_cfg.sweep_pace;
                n_active = (i_cfg.sweep_pace != '0) || (i_cfg.sweep_shift != '0);
                if (i_cfg.sweep_shift != '0 && w_sweep_a.overflow) begin
                    n_on     = 1'b0;
                    n_active = 1'b0;
                end
            end
            sqsw_pkg::MODE_TICK: begin
                if (r_active && i_cfg.sweep_pace != '0 && r_period != '0) begin
                    if (w_count_dec != '0) begin
                        n_count = w_count_dec;
                    end else begin
                        n_count = i_cfg.sweep_pace;
                        if (w_sweep_a.overflow) begin
                            n_on     = 1'b0;
                            n_active = 1'b0;
                        end else if (i_cfg.sweep_shift != '0) begin
                            n_shadow = w_sweep_a.value;
                            n_period = w_sweep_a.value;
                            if (w_sweep_b.overflow) begin
                                n_on     = 1'b0;
                                n_active = 1'b0;
                            end
                        end
                    end
                end
            end
            sqsw_pkg::MODE_DUTY: begin
                n_duty_pos = {r_duty_pos[0], r_duty_pos[sqsw_pkg::DUTY_STEPS-1:1]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_pos <= sqsw_pkg::DUTY_POS_RESET;
            r_active   <= 1'b0;
            r_count    <= '0;
            r_shadow   <= '0;
            r_period   <= '0;
            r_on       <= 1'b0;
        end else if (i_step) begin
            r_duty_pos <= n_duty_pos;
            r_active   <= n_active;
            r_count    <= n_count;
            r_shadow   <= n_shadow;
            r_period   <= n_period;
            r_on       <= n_on;
        end
    end

    assign w_high = |(sqsw_pkg::duty_pattern(i_cfg.duty_select) & n_duty_pos);

    assign o_result.duty_high = w_high;
    assign o_result.sample    = w_high ? i_volume : '0;
    assign o_result.enabled   = n_on;
    assign o_result.period    = n_period;

endmodule

// ----- hdl/square_channel_freq_sweep_unit.sv -----
// An accepted input beat passes through the input register, then the output register.
// Throughput: one beat per cycle while the output is not stalled; the channel state
// updates as the item leaves the input register, so each item sees the state left by the one before.
// Reset: synchronous, active low; clears the configuration, the channel state
// (duty position back to its top bit) and both valid flags; beat data is not reset.
module square_channel_freq_sweep_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_wr_en,
    input  logic [sqsw_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sqsw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [10:0] period_in, [14:11] volume, [15] zero
    input  logic [sqsw_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // [1:0] mode
    input  logic [sqsw_pkg::MODE_BITS-1:0]      i_s_axis_tuser,

    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [10:0] period_out, [11] enabled_out, [15:12] sample_out, [16] duty_high,
    // [23:17] zero
    output logic [sqsw_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    sqsw_pkg::t_cfg                   w_cfg;
    sqsw_pkg::t_result                w_result;
    logic                             w_advance;
    logic                             w_in_accept;

    logic                             r_in_valid;
    sqsw_pkg::t_mode                  r_in_mode;
    logic [sqsw_pkg::PERIOD_BITS-1:0] r_in_period;
    logic [sqsw_pkg::VOL_BITS-1:0]    r_in_volume;

    logic                             r_out_valid;
    sqsw_pkg::t_result                r_out;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    sqsw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    sqsw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_mode      (r_in_mode),
        .i_period_in (r_in_period),
        .i_volume    (r_in_volume),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_mode   <= sqsw_pkg::t_mode'(i_s_axis_tuser);
            r_in_period <= i_s_axis_tdata[sqsw_pkg::PERIOD_BITS-1:0];
            r_in_volume <= i_s_axis_tdata[sqsw_pkg::IN_FIELD_BITS-1:sqsw_pkg::PERIOD_BITS];
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = sqsw_pkg::OUT_TDATA_BITS'(r_out);

endmodule
